FILE: sv/bcr_pkg.sv
// Shared constants and types for the circle rasterizer.
// Used by every module of the block; depends on nothing else.
package bcr_pkg;

	// Fixed field widths of the configuration registers and results.
	localparam int CENTER_BITS = 12;
	localparam int RADIUS_BITS = 11;
	localparam int CFG_DATA_BITS = 12;
	localparam int CFG_INDEX_BITS = 2;
	localparam int PIX_BITS = 14;
	localparam int DEC_BITS = 16;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS = 2'd2;

	// Eight symmetric pixels per step, counted by a three-bit index.
	localparam int PIX_IDX_BITS = 3;
	localparam logic [PIX_IDX_BITS-1:0] LAST_PIX = 3'd7;

	// Decision value update constants.
	localparam logic [DEC_BITS-1:0] DEC_INIT = 16'd3;
	localparam logic [DEC_BITS-1:0] DEC_INC_KEEP = 16'd6;
	localparam logic [DEC_BITS-1:0] DEC_INC_STEP = 16'd10;

	// Step queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_BITS = 1;
	localparam int QUEUE_CNT_BITS = 2;

	typedef logic [CENTER_BITS-1:0] center_t;
	typedef logic [RADIUS_BITS-1:0] radius_t;
	typedef logic signed [PIX_BITS-1:0] pix_t;
	typedef logic signed [DEC_BITS-1:0] dec_t;

endpackage

FILE: sv/bresenham_circle_rasterizer.sv
// Bresenham circle rasterizer: each step request yields eight symmetric pixels.
// A step goes through the step queue, a step register and the output register.
// The output gives one pixel a cycle while out_ready does not stall it.
// The two-entry step queue lets requests be taken while earlier pixels drain.
// Reset clears the centre, radius and octant point and marks the circle finished,
// so steps without restart emit nothing until a restart request arrives.
module bresenham_circle_rasterizer #(
	parameter int COORD_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bcr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [bcr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output bcr_pkg::pix_t                        pixel_x,
	output bcr_pkg::pix_t                        pixel_y,
	output logic                                 color,
	output logic                                 last,
	output logic                                 done_res
);

	localparam int ENTRY_BITS = 2 * COORD_BITS + 1;

	bcr_pkg::center_t center_x_q;
	bcr_pkg::center_t center_y_q;
	bcr_pkg::radius_t radius_q;

	logic                  push;
	logic [ENTRY_BITS-1:0] push_data;
	logic                  full;
	logic                  pop;
	logic                  empty;
	logic [ENTRY_BITS-1:0] pop_data;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bcr_pkg::REG_CENTER_X: center_x_q <= cfg_data;
				bcr_pkg::REG_CENTER_Y: center_y_q <= cfg_data;
				bcr_pkg::REG_RADIUS:   radius_q <= cfg_data[bcr_pkg::RADIUS_BITS-1:0];
				default: ;
			endcase
		end
	end

	bcr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.radius    (radius_q),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	bcr_queue #(
		.WIDTH(ENTRY_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.pop_data  (pop_data)
	);

	bcr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.center_x  (center_x_q),
		.center_y  (center_y_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.color     (color),
		.last      (last),
		.done_res  (done_res)
	);

endmodule

FILE: sv/bcr_queue.sv
// Two-entry step queue between the front and back parts.
// Depends on bcr_pkg for the depth and pointer widths.
module bcr_queue #(
	parameter int WIDTH = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] entry_q [bcr_pkg::QUEUE_DEPTH];
	logic [bcr_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [bcr_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [bcr_pkg::QUEUE_CNT_BITS-1:0] count_q;

	// Status flags and the head entry.
	assign full = (count_q == bcr_pkg::QUEUE_CNT_BITS'(bcr_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/bcr_front.sv
// Front part: accepts step requests, keeps the octant point and decision value,
// and queues one entry for each step that emits. Depends on bcr_pkg.
module bcr_front #(
	parameter int COORD_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    restart,
	input  bcr_pkg::radius_t        radius,
	input  logic                    full,
	output logic                    push,
	output logic [2*COORD_BITS:0]   push_data
);

	logic [COORD_BITS-1:0] octant_p_q;
	logic [COORD_BITS-1:0] octant_q_q;
	bcr_pkg::dec_t         decision_q;
	logic                  finished_q;

	logic                  accept;
	logic [31:0]           radius_w;
	logic [COORD_BITS-1:0] p_eff;
	logic [COORD_BITS-1:0] q_eff;
	bcr_pkg::dec_t         d_eff;
	logic                  fin_eff;
	logic [31:0]           p_w;
	logic [31:0]           q_w;
	logic [bcr_pkg::DEC_BITS-1:0] p16;
	logic [bcr_pkg::DEC_BITS-1:0] diff16;
	logic                  step_q;
	bcr_pkg::dec_t         d_next;
	logic [COORD_BITS-1:0] q_next;
	logic [COORD_BITS:0]   np;
	logic signed [COORD_BITS+1:0] np_s;
	logic signed [COORD_BITS+1:0] nq_s;
	logic                  done;

	assign in_ready = !full;
	assign accept = in_valid && in_ready;

	// A restart reloads the point and decision value before the step runs.
	always_comb begin
		radius_w = 32'(radius);
		if (restart) begin
			p_eff = '0;
			q_eff = radius_w[COORD_BITS-1:0];
			d_eff = bcr_pkg::DEC_INIT - {radius_w[bcr_pkg::DEC_BITS-2:0], 1'b0};
			fin_eff = 1'b0;
		end else begin
			p_eff = octant_p_q;
			q_eff = octant_q_q;
			d_eff = decision_q;
			fin_eff = finished_q;
		end
	end

	// Decision update, next point and the end-of-circle test on true values.
	always_comb begin
		p_w = 32'(p_eff);
		q_w = 32'(q_eff);
		p16 = p_w[bcr_pkg::DEC_BITS-1:0];
		diff16 = p16 - q_w[bcr_pkg::DEC_BITS-1:0];
		step_q = (d_eff > 0);
		if (step_q) begin
			d_next = d_eff + {diff16[bcr_pkg::DEC_BITS-3:0], 2'b00} + bcr_pkg::DEC_INC_STEP;
			q_next = q_eff - 1'b1;
		end else begin
			d_next = d_eff + {p16[bcr_pkg::DEC_BITS-3:0], 2'b00} + bcr_pkg::DEC_INC_KEEP;
			q_next = q_eff;
		end
		np = {1'b0, p_eff} + 1'b1;
		np_s = signed'({1'b0, np});
		nq_s = signed'({2'b00, q_eff}) - signed'((COORD_BITS+2)'(step_q));
		done = !(np_s < nq_s);
	end

	// Queue entry: done flag, p, q.
	assign push = accept && !fin_eff;
	assign push_data = {done, p_eff, q_eff};

	// Octant state, updated by every step that emits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octant_p_q <= '0;
			octant_q_q <= '0;
			decision_q <= '0;
			finished_q <= 1'b1;
		end else if (push) begin
			octant_p_q <= np[COORD_BITS-1:0];
			octant_q_q <= q_next;
			decision_q <= d_next;
			finished_q <= done;
		end
	end

endmodule

FILE: sv/bcr_back.sv
// Back part: expands each queued step into its eight symmetric pixels,
// one per cycle while out_ready does not stall, through an output register. Depends on bcr_pkg.
module bcr_back #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  empty,
	input  logic [2*COORD_BITS:0] pop_data,
	output logic                  pop,
	input  bcr_pkg::center_t      center_x,
	input  bcr_pkg::center_t      center_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bcr_pkg::pix_t         pixel_x,
	output bcr_pkg::pix_t         pixel_y,
	output logic                  color,
	output logic                  last,
	output logic                  done_res
);

	logic                  cur_valid_q;
	logic [COORD_BITS-1:0] cur_p_q;
	logic [COORD_BITS-1:0] cur_q_q;
	logic                  cur_done_q;
	logic [bcr_pkg::PIX_IDX_BITS-1:0] idx_q;

	logic                  out_valid_q;
	bcr_pkg::pix_t         pixel_x_q;
	bcr_pkg::pix_t         pixel_y_q;
	logic                  color_q;
	logic                  last_q;
	logic                  done_q;

	logic                  advance;
	logic                  load_cur;
	logic [31:0]           p_w;
	logic [31:0]           q_w;
	bcr_pkg::pix_t         p14;
	bcr_pkg::pix_t         q14;
	bcr_pkg::pix_t         cx14;
	bcr_pkg::pix_t         cy14;
	logic                  swap;
	logic                  neg_x;
	logic                  neg_y;
	bcr_pkg::pix_t         op_x;
	bcr_pkg::pix_t         op_y;
	bcr_pkg::pix_t         pix_x;
	bcr_pkg::pix_t         pix_y;

	assign advance = !out_valid_q || out_ready;
	assign load_cur = !cur_valid_q ||
		(advance && (idx_q == bcr_pkg::LAST_PIX));
	assign pop = load_cur && !empty;

	// Pixel of the current index: octants swap p and q and flip signs.
	always_comb begin
		p_w = 32'(cur_p_q);
		q_w = 32'(cur_q_q);
		p14 = p_w[bcr_pkg::PIX_BITS-1:0];
		q14 = q_w[bcr_pkg::PIX_BITS-1:0];
		cx14 = bcr_pkg::PIX_BITS'(center_x);
		cy14 = bcr_pkg::PIX_BITS'(center_y);
		swap = idx_q[0] ^ idx_q[1];
		neg_x = idx_q[2];
		neg_y = idx_q[2] ^ idx_q[1];
		op_x = swap ? q14 : p14;
		op_y = swap ? p14 : q14;
		pix_x = neg_x ? (cx14 - op_x) : (cx14 + op_x);
		pix_y = neg_y ? (cy14 - op_y) : (cy14 + op_y);
	end

	// Current step and pixel index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (advance && cur_valid_q) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_cur) begin
				cur_valid_q <= !empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_done_q <= pop_data[2*COORD_BITS];
			cur_p_q <= pop_data[2*COORD_BITS-1:COORD_BITS];
			cur_q_q <= pop_data[COORD_BITS-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= cur_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cur_valid_q) begin
			pixel_x_q <= pix_x;
			pixel_y_q <= pix_y;
			color_q <= idx_q[0];
			last_q <= (idx_q == bcr_pkg::LAST_PIX);
			done_q <= cur_done_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x = pixel_x_q;
	assign pixel_y = pixel_y_q;
	assign color = color_q;
	assign last = last_q;
	assign done_res = done_q;

endmodule
